### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker files of the cache core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/dmwtc_pkg.sv
// ----------------------------------------------------------------------------
// dmwtc_pkg
// Types, widths and codes shared by the cache core modules.
// ----------------------------------------------------------------------------
package dmwtc_pkg;

    // field widths
    localparam int ADDR_W    = 5;
    localparam int BYTE_W    = 8;
    localparam int BLK_W     = ADDR_W - 1;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    // the byte address reaches this many store locations at most
    localparam int MEM_SPAN = 1 << ADDR_W;

    // parameter defaults
    localparam int LINE_COUNT_DEF = 8;
    localparam int MEM_BYTES_DEF  = 32;

    // request kinds carried on s_tuser
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // one cache line: block number (tag and index together) and two bytes
    typedef struct packed {
        logic [BLK_W-1:0]  blk;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b0;
    } line_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture request, read line and block
        logic commit;  // resolve access, update stores, fill output
    } cmd_t;

endpackage

### rtl/core/dmwtc_ctrl.sv
// ----------------------------------------------------------------------------
// dmwtc_ctrl
// Access sequencer: accepts an item, then commits it once the output
// register is free, and owns the result valid flag.
// ----------------------------------------------------------------------------
module dmwtc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output dmwtc_pkg::cmd_t    cmd
);
    import dmwtc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.commit = (state_reg == ST_EXEC) && out_free;
    assign m_tvalid   = m_tvalid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // result valid flag
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

### rtl/core/dmwtc_datapath.sv
// ----------------------------------------------------------------------------
// dmwtc_datapath
// Line store, backing store and result register. Reads both stores when an
// item is loaded, resolves hit, fill and write-through on commit.
// ----------------------------------------------------------------------------
module dmwtc_datapath #(
    parameter int LINE_COUNT = dmwtc_pkg::LINE_COUNT_DEF,
    parameter int MEM_BYTES  = dmwtc_pkg::MEM_BYTES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  dmwtc_pkg::cmd_t                    cmd,
    input  logic [dmwtc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tuser,
    output logic [dmwtc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                               m_tuser
);
    import dmwtc_pkg::*;

    localparam int IDX_W     = $clog2(LINE_COUNT);
    localparam int MEM_DEPTH = (MEM_BYTES < MEM_SPAN) ? MEM_BYTES : MEM_SPAN;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int MX_W      = ADDR_W + 1;

    // remainder by a constant: conditional subtract of shifted multiples
    function automatic logic [MX_W-1:0] rem_by(input logic [MX_W-1:0] x, input int m);
        logic [MX_W-1:0] r;
        r = x;
        for (int k = MX_W - 1; k >= 0; k--) begin
            if ((int'(r) >> k) >= m) r = r - MX_W'(m << k);
        end
        return r;
    endfunction

    // input fields
    logic [ADDR_W-1:0] in_addr;
    logic [BYTE_W-1:0] in_wval;
    logic [BLK_W-1:0]  in_blk;
    logic [IDX_W-1:0]  in_idx;
    logic [MX_W-1:0]   in_base;
    logic [MEM_AW-1:0] in_i0, in_i1;

    assign in_addr = s_tdata[ADDR_W-1:0];
    assign in_wval = s_tdata[ADDR_W +: BYTE_W];
    assign in_blk  = in_addr[ADDR_W-1:1];
    assign in_idx  = IDX_W'(rem_by(MX_W'(in_blk), LINE_COUNT));
    assign in_base = {1'b0, in_blk, 1'b0};
    assign in_i0   = MEM_AW'(rem_by(in_base, MEM_DEPTH));
    assign in_i1   = MEM_AW'(rem_by(in_base + MX_W'(1), MEM_DEPTH));

    // stores
    line_t             line_mem [LINE_COUNT];
    logic              line_vld_reg [LINE_COUNT];
    logic [BYTE_W-1:0] byte_mem [MEM_DEPTH];
    logic              byte_vld_reg [MEM_DEPTH];

    // request and read data captured at load
    logic              req_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [BYTE_W-1:0] wval_reg;
    logic [IDX_W-1:0]  idx_reg;
    line_t             line_rd_reg;
    logic              lv_rd_reg;
    logic [BYTE_W-1:0] rd0_reg, rd1_reg;
    logic              v0_reg, v1_reg;

    // result register
    logic [BYTE_W-1:0] read_value_reg, read_value_next;
    logic              hit_reg, hit_next;

    // commit-time values
    logic              is_write;
    logic              off;
    logic [BYTE_W-1:0] nb0, nb1;
    logic [MEM_AW-1:0] wr_idx;
    line_t             line_wr;

    assign is_write = (req_reg == REQ_WRITE);
    assign off      = addr_reg[0];
    assign wr_idx   = MEM_AW'(rem_by(MX_W'(addr_reg), MEM_DEPTH));
    assign hit_next = lv_rd_reg && (line_rd_reg.blk == addr_reg[ADDR_W-1:1]);

    // line contents after fill and write
    always_comb begin
        nb0 = hit_next ? line_rd_reg.b0 : (v0_reg ? rd0_reg : '0);
        nb1 = hit_next ? line_rd_reg.b1 : (v1_reg ? rd1_reg : '0);
        if (is_write) begin
            if (off) nb1 = wval_reg;
            else     nb0 = wval_reg;
        end
        line_wr.blk     = addr_reg[ADDR_W-1:1];
        line_wr.b1      = nb1;
        line_wr.b0      = nb0;
        read_value_next = off ? nb1 : nb0;
    end

    // capture request and read both stores
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg     <= s_tuser;
            addr_reg    <= in_addr;
            wval_reg    <= in_wval;
            idx_reg     <= in_idx;
            line_rd_reg <= line_mem[in_idx];
            lv_rd_reg   <= line_vld_reg[in_idx];
            rd0_reg     <= byte_mem[in_i0];
            rd1_reg     <= byte_mem[in_i1];
            v0_reg      <= byte_vld_reg[in_i0];
            v1_reg      <= byte_vld_reg[in_i1];
        end
    end

    // line and store updates, result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            line_mem[idx_reg] <= line_wr;
            read_value_reg    <= read_value_next;
            hit_reg           <= hit_next;
            if (is_write) byte_mem[wr_idx] <= wval_reg;
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LINE_COUNT; i++) line_vld_reg[i] <= 1'b0;
            for (int i = 0; i < MEM_DEPTH; i++)  byte_vld_reg[i] <= 1'b0;
        end else if (cmd.commit) begin
            line_vld_reg[idx_reg] <= 1'b1;
            if (is_write) byte_vld_reg[wr_idx] <= 1'b1;
        end
    end

    assign m_tdata = read_value_reg;
    assign m_tuser = hit_reg;

endmodule

### rtl/core/direct_mapped_write_through_cache_core.sv
// Flow: an accepted item's request and store reads are registered at load, and
// its result register is filled at commit, which waits while m_tready holds
// the previous result back. No new item is taken until the last one commits,
// since each passes through the line and backing stores in load then commit.
// Reset: aresetn clears the controller, the output valid flag and the valid
// bits of both stores, so all lines are invalid and all bytes read as zero.
// ----------------------------------------------------------------------------
// direct_mapped_write_through_cache_core
// Direct-mapped write-through, write-allocate cache in front of a byte-wide
// backing store, one result item per request item.
// ----------------------------------------------------------------------------
module direct_mapped_write_through_cache_core #(
    parameter int LINE_COUNT = dmwtc_pkg::LINE_COUNT_DEF,
    parameter int MEM_BYTES  = dmwtc_pkg::MEM_BYTES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dmwtc_pkg::S_TDATA_W-1:0]    s_tdata,   // address[4:0], write_value[12:5]
    input  logic                               s_tuser,   // req_type
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dmwtc_pkg::M_TDATA_W-1:0]    m_tdata,   // read_value[7:0]
    output logic                               m_tuser    // hit
);
    import dmwtc_pkg::*;

    cmd_t cmd;

    // sequencer
    dmwtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // stores and result
    dmwtc_datapath #(
        .LINE_COUNT (LINE_COUNT),
        .MEM_BYTES  (MEM_BYTES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

### rtl/core/dmwtc_checker.sv
// ----------------------------------------------------------------------------
// dmwtc_checker
// Port-level checks of the cache core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmwtc_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [dmwtc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [dmwtc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                               m_tuser
);
    import dmwtc_pkg::*;

    logic s_acc;
    logic out_free;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    // a held result keeps its payload
    `ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // one item in flight: no accept right after an accept
    `ASSERT_NXT(a_one_busy, aclk, aresetn, s_acc, !s_tready, "item accepted while busy")

    // with a free output at accept the commit does not stall and the result shows
    `ASSERT_IMP(a_latency, aclk, aresetn, s_acc && out_free, ##2 m_tvalid, "result late")

    // a write returns its own byte
    `ASSERT_IMP(a_wr_echo, aclk, aresetn, s_acc && out_free && (s_tuser == REQ_WRITE), ##2 (m_tdata == $past(s_tdata[ADDR_W +: BYTE_W], 2)), "write result mismatch")

endmodule

bind direct_mapped_write_through_cache_core dmwtc_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
